>>> rtl/xobe_pkg.sv
// ----------------------------------------------------------------------------
// xobe_pkg
// Shared types and constants of the x86-64 operation byte encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package xobe_pkg;

    localparam int unsigned IN_TDATA_W  = 80;
    localparam int unsigned OUT_TDATA_W = 160;
    localparam int unsigned NUM_BYTES   = 15;

    typedef enum logic [3:0] {
        OP_SET      = 4'd0,
        OP_COPY     = 4'd1,
        OP_SYSCALL  = 4'd2,
        OP_NOP_PAD  = 4'd3,
        OP_JZ       = 4'd4,
        OP_JNZ      = 4'd5,
        OP_INC_REG  = 4'd6,
        OP_DEC_REG  = 4'd7,
        OP_INC_BYTE = 4'd8,
        OP_DEC_BYTE = 4'd9,
        OP_ADD      = 4'd10,
        OP_SUB      = 4'd11,
        OP_ADD_BYTE = 4'd12,
        OP_SUB_BYTE = 4'd13,
        OP_ZERO_BYTE = 4'd14
    } t_op;

    // Instruction byte values.
    localparam logic [7:0] B_MOV_RR    = 8'h89;
    localparam logic [7:0] B_ESC       = 8'h0f;
    localparam logic [7:0] B_SYSCALL   = 8'h05;
    localparam logic [7:0] B_NOP       = 8'h90;
    localparam logic [7:0] B_TEST_B    = 8'hf6;
    localparam logic [7:0] B_PUSH_I8   = 8'h6a;
    localparam logic [7:0] B_POP       = 8'h58;
    localparam logic [7:0] B_PUSH      = 8'h50;
    localparam logic [7:0] B_MOV_RI    = 8'hb8;
    localparam logic [7:0] B_GRP1_I8   = 8'h83;
    localparam logic [7:0] B_GRP1_I32  = 8'h81;
    localparam logic [7:0] B_GRP1_B    = 8'h80;
    localparam logic [7:0] B_ADDR32    = 8'h67;
    localparam logic [7:0] B_XOR_RR    = 8'h31;
    localparam logic [7:0] B_REX_W     = 8'h48;
    localparam logic [7:0] B_ADD_RR    = 8'h01;
    localparam logic [7:0] B_SUB_RR    = 8'h29;
    localparam logic [7:0] B_INCDEC    = 8'hff;
    localparam logic [7:0] B_INCDEC_B  = 8'hfe;
    localparam logic [7:0] B_MOV_B_I8  = 8'hc6;
    localparam logic [7:0] B_JCC_BASE  = 8'h80;
    localparam logic [7:0] B_MODRM_REG = 8'hc0;
    localparam logic [7:0] B_EXT_SUB   = 8'he8;
    localparam logic [7:0] B_EXT_DEC   = 8'hc8;
    localparam logic [3:0] COND_Z      = 4'h4;
    localparam logic [3:0] COND_NZ     = 4'h5;

    typedef struct packed {
        logic [55:0] last_bytes;
        logic [63:0] first_bytes;
        logic [3:0]  byte_count;
        logic        error_flag;
    } t_enc;

endpackage

`default_nettype wire

>>> rtl/xobe_encoder.sv
// ----------------------------------------------------------------------------
// xobe_encoder
// Combinational encoder: turns one operation request into its code bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module xobe_encoder (
    input  wire logic [3:0]         i_opcode,
    input  wire logic [2:0]         i_target_reg,
    input  wire logic [2:0]         i_source_reg,
    input  wire logic signed [63:0] i_immediate,
    output xobe_pkg::t_enc          o_enc
);

    logic [7:0] b [xobe_pkg::NUM_BYTES];
    logic [3:0] cnt;
    logic       err;
    logic       imm_zero;
    logic       fits8;
    logic       fits32;
    logic [7:0] dst8;
    logic [7:0] ext;
    logic [7:0] tmp8;
    logic [63:0] first;
    logic [55:0] last;

    // A value fits a signed width when all bits above its sign bit copy the sign.
    assign imm_zero = (i_immediate == 64'sd0);
    assign fits8    = (&i_immediate[63:7]) | ~(|i_immediate[63:7]);
    assign fits32   = (&i_immediate[63:31]) | ~(|i_immediate[63:31]);
    assign dst8     = {5'd0, i_target_reg};
    assign ext      = (i_opcode == xobe_pkg::OP_SUB) ? xobe_pkg::B_EXT_SUB
                                                     : xobe_pkg::B_MODRM_REG;
    // Scratch register for the 64-bit add/sub sequence.
    assign tmp8     = (i_target_reg == 3'd0) ? 8'd1 : 8'd0;

    always_comb begin
        for (int k = 0; k < xobe_pkg::NUM_BYTES; k++) begin
            b[k] = 8'h00;
        end
        cnt = 4'd0;
        err = 1'b0;
        case (i_opcode)
            xobe_pkg::OP_SET: begin
                if (imm_zero) begin
                    b[0] = xobe_pkg::B_XOR_RR;
                    b[1] = xobe_pkg::B_MODRM_REG | {2'b00, i_target_reg, i_target_reg};
                    cnt  = 4'd2;
                end else if (fits8) begin
                    b[0] = xobe_pkg::B_PUSH_I8;
                    b[1] = i_immediate[7:0];
                    b[2] = xobe_pkg::B_POP + dst8;
                    cnt  = 4'd3;
                end else if (fits32) begin
                    b[0] = xobe_pkg::B_MOV_RI | dst8;
                    for (int k = 0; k < 4; k++) begin
                        b[1 + k] = i_immediate[8*k +: 8];
                    end
                    cnt  = 4'd5;
                end else begin
                    b[0] = xobe_pkg::B_REX_W;
                    b[1] = xobe_pkg::B_MOV_RI | dst8;
                    for (int k = 0; k < 8; k++) begin
                        b[2 + k] = i_immediate[8*k +: 8];
                    end
                    cnt  = 4'd10;
                end
            end
            xobe_pkg::OP_COPY: begin
                b[0] = xobe_pkg::B_MOV_RR;
                b[1] = xobe_pkg::B_MODRM_REG | {2'b00, i_source_reg, i_target_reg};
                cnt  = 4'd2;
            end
            xobe_pkg::OP_SYSCALL: begin
                b[0] = xobe_pkg::B_ESC;
                b[1] = xobe_pkg::B_SYSCALL;
                cnt  = 4'd2;
            end
            xobe_pkg::OP_NOP_PAD: begin
                for (int k = 0; k < 9; k++) begin
                    b[k] = xobe_pkg::B_NOP;
                end
                cnt = 4'd9;
            end
            xobe_pkg::OP_JZ, xobe_pkg::OP_JNZ: begin
                if (!fits32) begin
                    err = 1'b1;
                end else begin
                    // Test the byte at the pointer, then a conditional near jump.
                    b[0] = xobe_pkg::B_TEST_B;
                    b[1] = dst8;
                    b[2] = xobe_pkg::B_INCDEC;
                    b[3] = xobe_pkg::B_ESC;
                    b[4] = xobe_pkg::B_JCC_BASE | {4'd0,
                           (i_opcode == xobe_pkg::OP_JZ) ? xobe_pkg::COND_Z
                                                         : xobe_pkg::COND_NZ};
                    for (int k = 0; k < 4; k++) begin
                        b[5 + k] = i_immediate[8*k +: 8];
                    end
                    cnt = 4'd9;
                end
            end
            xobe_pkg::OP_INC_REG: begin
                b[0] = xobe_pkg::B_INCDEC;
                b[1] = xobe_pkg::B_MODRM_REG | dst8;
                cnt  = 4'd2;
            end
            xobe_pkg::OP_DEC_REG: begin
                b[0] = xobe_pkg::B_INCDEC;
                b[1] = xobe_pkg::B_EXT_DEC | dst8;
                cnt  = 4'd2;
            end
            xobe_pkg::OP_INC_BYTE: begin
                b[0] = xobe_pkg::B_INCDEC_B;
                b[1] = dst8;
                cnt  = 4'd2;
            end
            xobe_pkg::OP_DEC_BYTE: begin
                b[0] = xobe_pkg::B_INCDEC_B;
                b[1] = 8'h08 | dst8;
                cnt  = 4'd2;
            end
            xobe_pkg::OP_ADD, xobe_pkg::OP_SUB: begin
                // The short forms exclude the top value of their range.
                if (imm_zero) begin
                    cnt = 4'd0;
                end else if (fits8 && (i_immediate[7:0] != 8'h7f)) begin
                    b[0] = xobe_pkg::B_GRP1_I8;
                    b[1] = ext + dst8;
                    b[2] = i_immediate[7:0];
                    cnt  = 4'd3;
                end else if (fits32 && (i_immediate[31:0] != 32'h7fff_ffff)) begin
                    b[0] = xobe_pkg::B_GRP1_I32;
                    b[1] = ext + dst8;
                    for (int k = 0; k < 4; k++) begin
                        b[2 + k] = i_immediate[8*k +: 8];
                    end
                    cnt  = 4'd6;
                end else begin
                    b[0] = xobe_pkg::B_PUSH + tmp8;
                    b[1] = xobe_pkg::B_REX_W;
                    b[2] = xobe_pkg::B_MOV_RI + tmp8;
                    for (int k = 0; k < 8; k++) begin
                        b[3 + k] = i_immediate[8*k +: 8];
                    end
                    b[11] = xobe_pkg::B_REX_W;
                    b[12] = (i_opcode == xobe_pkg::OP_SUB) ? xobe_pkg::B_SUB_RR
                                                           : xobe_pkg::B_ADD_RR;
                    b[13] = xobe_pkg::B_MODRM_REG + {tmp8[4:0], 3'b000} + dst8;
                    b[14] = xobe_pkg::B_POP + tmp8;
                    cnt   = 4'd15;
                end
            end
            xobe_pkg::OP_ADD_BYTE: begin
                b[0] = xobe_pkg::B_GRP1_B;
                b[1] = dst8;
                b[2] = i_immediate[7:0];
                cnt  = 4'd3;
            end
            xobe_pkg::OP_SUB_BYTE: begin
                b[0] = xobe_pkg::B_GRP1_B;
                b[1] = 8'h28 + dst8;
                b[2] = i_immediate[7:0];
                cnt  = 4'd3;
            end
            xobe_pkg::OP_ZERO_BYTE: begin
                b[0] = xobe_pkg::B_ADDR32;
                b[1] = xobe_pkg::B_MOV_B_I8;
                b[2] = dst8;
                b[3] = 8'h00;
                cnt  = 4'd4;
            end
            default: begin
                cnt = 4'd0;
            end
        endcase
    end

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            first[8*k +: 8] = b[k];
        end
        for (int k = 0; k < 7; k++) begin
            last[8*k +: 8] = b[8 + k];
        end
    end

    assign o_enc.first_bytes = first;
    assign o_enc.last_bytes  = last;
    assign o_enc.byte_count  = cnt;
    assign o_enc.error_flag  = err;

endmodule

`default_nettype wire

>>> rtl/x86_64_op_byte_encoder.sv
// Each item passes through the input register, then the result register,
// before its result is presented.
// One item per cycle while the sink takes results; the only loop is the 32-bit offset adder.
// Reset clears both valid flags and the running byte offset to zero.
// ----------------------------------------------------------------------------
// x86_64_op_byte_encoder
// Encodes one operation request per item into x86-64 code bytes and keeps a
// running byte offset.
// ----------------------------------------------------------------------------
`default_nettype none

module x86_64_op_byte_encoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [3:0] opcode, [6:4] target_reg, [9:7] source_reg, [73:10] immediate
    input  wire logic [xobe_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [63:0] first_bytes, [119:64] last_bytes, [123:120] byte_count,
    // [124] error_flag, [156:125] end_offset
    output logic [xobe_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic        r_in_valid;
    logic [3:0]  r_opcode;
    logic [2:0]  r_target_reg;
    logic [2:0]  r_source_reg;
    logic signed [63:0] r_immediate;

    logic        r_out_valid;
    xobe_pkg::t_enc r_out;
    logic [31:0] r_out_offset;
    logic [31:0] r_total;
    logic [31:0] n_total;

    xobe_pkg::t_enc enc;
    logic in_take;
    logic out_load;
    logic out_free;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign out_load      = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    xobe_encoder u_encoder (
        .i_opcode     (r_opcode),
        .i_target_reg (r_target_reg),
        .i_source_reg (r_source_reg),
        .i_immediate  (r_immediate),
        .o_enc        (enc)
    );

    assign n_total = r_total + {28'd0, enc.byte_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (in_take) begin
            r_opcode     <= s_axis_tdata[3:0];
            r_target_reg <= s_axis_tdata[6:4];
            r_source_reg <= s_axis_tdata[9:7];
            r_immediate  <= s_axis_tdata[73:10];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_total     <= 32'd0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (out_load) begin
                r_total <= n_total;
            end
        end
        if (out_load) begin
            r_out        <= enc;
            r_out_offset <= n_total;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out_offset, r_out.error_flag, r_out.byte_count,
                            r_out.last_bytes, r_out.first_bytes};

    // The held result always reports the offset the block is at now.
    a_offset_tracks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_offset == r_total))
        else $error("end offset out of step with running total");

    a_err_no_bytes : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.error_flag) |-> (r_out.byte_count == 4'd0))
        else $error("jump error with bytes emitted");

    a_empty_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.byte_count == 4'd0)) |->
        ((r_out.first_bytes == 64'd0) && (r_out.last_bytes == 56'd0)))
        else $error("bytes present in an empty result");

    a_in_held : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> r_in_valid)
        else $error("stalled item dropped from input register");

endmodule

`default_nettype wire

>>> tb/sv/x86_64_op_byte_encoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// x86_64_op_byte_encoder_tb
// Self-checking testbench: drives operation requests into the encoder,
// predicts the code bytes and the running offset for each one and checks
// every result in order, under several source and sink throttling phases.
// ----------------------------------------------------------------------------
module x86_64_op_byte_encoder_tb;

    localparam logic [3:0]  OP_UNDEFINED  = 4'd15;
    localparam longint      S8_MIN        = -64'sd128;
    localparam longint      S8_MAX        = 64'sd127;
    localparam longint      S32_MIN       = -64'sh8000_0000;
    localparam longint      S32_MAX       = 64'sh7fff_ffff;
    localparam int unsigned ITEMS_PER_PHASE = 275;
    localparam int unsigned DRAIN_CYCLES  = 10;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [2:0]  dst;
        logic [2:0]  src;
        logic [63:0] imm;
    } t_req;

    // Laid out exactly as the low 157 bits of the result item.
    typedef struct packed {
        logic [31:0] offset;
        logic        err;
        logic [3:0]  count;
        logic [55:0] last;
        logic [63:0] first;
    } t_code;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // opcode, target_reg, source_reg, immediate (lowest bit up)
    logic [79:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // first_bytes, last_bytes, byte_count, error_flag, end_offset (lowest bit up)
    logic [159:0] m_axis_tdata;

    t_req        pending_reqs [$];
    t_code       expected_code [$];
    logic        item_taken = 1'b0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned result_count = 0;
    int unsigned cycle_count = 0;

    // Predictor state.
    logic [7:0]  code_buf [xobe_pkg::NUM_BYTES];
    int unsigned code_len;
    logic [31:0] code_offset = '0;

    x86_64_op_byte_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void put_byte(logic [7:0] b);
        if (code_len < xobe_pkg::NUM_BYTES) begin
            code_buf[code_len] = b;
            code_len++;
        end
    endfunction

    function automatic void put_le(logic [63:0] v, int unsigned n);
        for (int unsigned i = 0; i < n; i++) put_byte(v[8*i +: 8]);
    endfunction

    function automatic void put_jump(logic [2:0] dst, logic [3:0] cond, logic [63:0] imm,
                                     inout logic err);
        longint off;
        off = imm;
        if (off > S32_MAX || off < S32_MIN) begin
            err = 1'b1;
        end else begin
            // test byte [reg], 0xff followed by a near conditional jump.
            put_byte(xobe_pkg::B_TEST_B);
            put_byte({5'b0, dst});
            put_byte(8'hff);
            put_byte(xobe_pkg::B_ESC);
            put_byte(xobe_pkg::B_JCC_BASE | {4'b0, cond});
            put_le(imm, 4);
        end
    endfunction

    function automatic void put_add_sub(logic [2:0] dst, logic [63:0] imm, logic is_sub);
        longint     v;
        logic [7:0] ext;
        logic [2:0] tmp;
        v = imm;
        ext = is_sub ? xobe_pkg::B_EXT_SUB : xobe_pkg::B_MODRM_REG;
        tmp = (dst != 3'd0) ? 3'd0 : 3'd1;
        // The upper bounds are exclusive, so 127 and 2^31-1 take the next form.
        if (v == 0) begin
            return;
        end else if (v >= S8_MIN && v < S8_MAX) begin
            put_byte(xobe_pkg::B_GRP1_I8);
            put_byte(ext + dst);
            put_byte(imm[7:0]);
        end else if (v >= S32_MIN && v < S32_MAX) begin
            put_byte(xobe_pkg::B_GRP1_I32);
            put_byte(ext + dst);
            put_le(imm, 4);
        end else begin
            // Borrow a scratch register through the stack for a 64-bit value.
            put_byte(xobe_pkg::B_PUSH + tmp);
            put_byte(xobe_pkg::B_REX_W);
            put_byte(xobe_pkg::B_MOV_RI + tmp);
            put_le(imm, 8);
            put_byte(xobe_pkg::B_REX_W);
            put_byte(is_sub ? xobe_pkg::B_SUB_RR : xobe_pkg::B_ADD_RR);
            put_byte(xobe_pkg::B_MODRM_REG + {2'b0, tmp, 3'b0} + dst);
            put_byte(xobe_pkg::B_POP + tmp);
        end
    endfunction

    function automatic t_code encode_request(t_req r);
        t_code  c;
        longint v;
        logic   err;
        v = r.imm;
        err = 1'b0;
        code_len = 0;
        foreach (code_buf[i]) code_buf[i] = '0;
        case (r.opcode)
            xobe_pkg::OP_SET: begin
                if (v == 0) begin
                    put_byte(xobe_pkg::B_XOR_RR);
                    put_byte(xobe_pkg::B_MODRM_REG | {2'b0, r.dst, r.dst});
                end else if (v >= S8_MIN && v <= S8_MAX) begin
                    put_byte(xobe_pkg::B_PUSH_I8);
                    put_byte(r.imm[7:0]);
                    put_byte(xobe_pkg::B_POP + r.dst);
                end else if (v >= S32_MIN && v <= S32_MAX) begin
                    put_byte(xobe_pkg::B_MOV_RI | r.dst);
                    put_le(r.imm, 4);
                end else begin
                    put_byte(xobe_pkg::B_REX_W);
                    put_byte(xobe_pkg::B_MOV_RI | r.dst);
                    put_le(r.imm, 8);
                end
            end
            xobe_pkg::OP_COPY: begin
                put_byte(xobe_pkg::B_MOV_RR);
                put_byte(xobe_pkg::B_MODRM_REG + {2'b0, r.src, r.dst});
            end
            xobe_pkg::OP_SYSCALL: begin
                put_byte(xobe_pkg::B_ESC);
                put_byte(xobe_pkg::B_SYSCALL);
            end
            xobe_pkg::OP_NOP_PAD: begin
                repeat (9) put_byte(xobe_pkg::B_NOP);
            end
            xobe_pkg::OP_JZ:  put_jump(r.dst, xobe_pkg::COND_Z, r.imm, err);
            xobe_pkg::OP_JNZ: put_jump(r.dst, xobe_pkg::COND_NZ, r.imm, err);
            xobe_pkg::OP_INC_REG: begin
                put_byte(xobe_pkg::B_INCDEC);
                put_byte(xobe_pkg::B_MODRM_REG | r.dst);
            end
            xobe_pkg::OP_DEC_REG: begin
                put_byte(xobe_pkg::B_INCDEC);
                put_byte(xobe_pkg::B_EXT_DEC | r.dst);
            end
            xobe_pkg::OP_INC_BYTE: begin
                put_byte(xobe_pkg::B_INCDEC_B);
                put_byte({5'b0, r.dst});
            end
            xobe_pkg::OP_DEC_BYTE: begin
                put_byte(xobe_pkg::B_INCDEC_B);
                put_byte(8'h08 | r.dst);
            end
            xobe_pkg::OP_ADD: put_add_sub(r.dst, r.imm, 1'b0);
            xobe_pkg::OP_SUB: put_add_sub(r.dst, r.imm, 1'b1);
            xobe_pkg::OP_ADD_BYTE: begin
                put_byte(xobe_pkg::B_GRP1_B);
                put_byte({5'b0, r.dst});
                put_byte(r.imm[7:0]);
            end
            xobe_pkg::OP_SUB_BYTE: begin
                put_byte(xobe_pkg::B_GRP1_B);
                put_byte(8'h28 + r.dst);
                put_byte(r.imm[7:0]);
            end
            xobe_pkg::OP_ZERO_BYTE: begin
                put_byte(xobe_pkg::B_ADDR32);
                put_byte(xobe_pkg::B_MOV_B_I8);
                put_byte({5'b0, r.dst});
                put_byte(8'h00);
            end
            default: ;
        endcase
        for (int i = 0; i < 8; i++) c.first[8*i +: 8] = code_buf[i];
        for (int i = 0; i < 7; i++) c.last[8*i +: 8] = code_buf[8 + i];
        c.count = 4'(code_len);
        c.err = err;
        code_offset = code_offset + 32'(code_len);
        c.offset = code_offset;
        return c;
    endfunction

    function automatic void add_req(logic [3:0] op, logic [2:0] dst, logic [2:0] src,
                                    logic [63:0] imm);
        pending_reqs.push_back({op, dst, src, imm});
    endfunction

    // Acceptance of an input item: predict its result and retire it.
    always @(posedge i_clk) begin
        item_taken <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready) begin
            expected_code.push_back(encode_request(pending_reqs.pop_front()));
        end
    end

    // Driver: a presented item is held until it is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || item_taken) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {6'b0, pending_reqs[0].imm, pending_reqs[0].src,
                                 pending_reqs[0].dst, pending_reqs[0].opcode};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin : monitor
        t_code got;
        t_code want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else if (m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[156:0];
            result_count++;
            if (expected_code.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result %0d arrived with no request outstanding: %h",
                             result_count, got);
            end else begin
                want = expected_code.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result %0d expected/actual: first %h/%h last %h/%h ",
                                  "count %0d/%0d err %0b/%0b offset %0d/%0d"},
                                 result_count, want.first, got.first, want.last, got.last,
                                 want.count, got.count, want.err, got.err,
                                 want.offset, got.offset);
                end
            end
        end
    end

    initial begin
        logic [31:0] rnd;
        logic [63:0] imm;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 54; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 54; end
                default: begin src_idle_pct = 29; sink_stall_pct = 29; end
            endcase

            if (phase == 0) begin
                // Set-register forms: zero, imm8 push/pop, imm32 and imm64.
                add_req(xobe_pkg::OP_SET, 3'd3, 3'd0, 64'd0);
                add_req(xobe_pkg::OP_SET, 3'd7, 3'd0, 64'hffff_ffff_ffff_ff80);
                add_req(xobe_pkg::OP_SET, 3'd0, 3'd0, 64'd127);
                add_req(xobe_pkg::OP_SET, 3'd5, 3'd0, 64'h7fff_ffff);
                add_req(xobe_pkg::OP_SET, 3'd2, 3'd0, 64'hffff_ffff_7fff_ffff);
                add_req(xobe_pkg::OP_SET, 3'd6, 3'd0, 64'h8000_0000_0000_0000);
                add_req(xobe_pkg::OP_COPY, 3'd7, 3'd7, '1);
                add_req(xobe_pkg::OP_COPY, 3'd0, 3'd5, 64'd0);
                add_req(xobe_pkg::OP_SYSCALL, 3'd0, 3'd0, 64'd0);
                add_req(xobe_pkg::OP_NOP_PAD, 3'd4, 3'd2, 64'd0);
                // Jumps at the edges of the 32-bit range and just outside it.
                add_req(xobe_pkg::OP_JZ, 3'd4, 3'd0, 64'h7fff_ffff);
                add_req(xobe_pkg::OP_JNZ, 3'd1, 3'd0, 64'hffff_ffff_8000_0000);
                add_req(xobe_pkg::OP_JZ, 3'd0, 3'd0, 64'h8000_0000);
                add_req(xobe_pkg::OP_JNZ, 3'd7, 3'd0, 64'h8000_0000_0000_0000);
                add_req(xobe_pkg::OP_INC_REG, 3'd7, 3'd0, 64'd0);
                add_req(xobe_pkg::OP_DEC_REG, 3'd0, 3'd0, 64'd0);
                add_req(xobe_pkg::OP_INC_BYTE, 3'd3, 3'd0, 64'd0);
                add_req(xobe_pkg::OP_DEC_BYTE, 3'd6, 3'd0, 64'd0);
                // Add/sub: zero emits nothing, 127 and 2^31-1 step up a form.
                add_req(xobe_pkg::OP_ADD, 3'd2, 3'd0, 64'd0);
                add_req(xobe_pkg::OP_ADD, 3'd0, 3'd0, 64'd127);
                add_req(xobe_pkg::OP_SUB, 3'd4, 3'd0, 64'hffff_ffff_ffff_ff80);
                add_req(xobe_pkg::OP_SUB, 3'd1, 3'd0, 64'h7fff_ffff);
                add_req(xobe_pkg::OP_ADD, 3'd0, 3'd0, 64'h7fff_ffff_ffff_ffff);
                add_req(xobe_pkg::OP_SUB, 3'd5, 3'd0, 64'hffff_ffff_7fff_ffff);
                add_req(xobe_pkg::OP_ADD_BYTE, 3'd7, 3'd0, '1);
                add_req(xobe_pkg::OP_SUB_BYTE, 3'd0, 3'd0, 64'h80);
                add_req(xobe_pkg::OP_ZERO_BYTE, 3'd5, 3'd0, 64'd0);
                add_req(OP_UNDEFINED, 3'd7, 3'd7, '1);
            end

            repeat (ITEMS_PER_PHASE) begin
                rnd = $urandom;
                // Weight the immediate toward the form boundaries.
                case ($urandom_range(9))
                    0: imm = '0;
                    1, 2: imm = {{56{rnd[7]}}, rnd[7:0]};
                    3, 4: imm = {{32{rnd[31]}}, rnd};
                    5: begin
                        case ($urandom_range(7))
                            0: imm = 64'd127;
                            1: imm = 64'd126;
                            2: imm = 64'hffff_ffff_ffff_ff80;
                            3: imm = 64'hffff_ffff_ffff_ff7f;
                            4: imm = 64'h7fff_ffff;
                            5: imm = 64'h7fff_fffe;
                            6: imm = 64'hffff_ffff_8000_0000;
                            default: imm = 64'h8000_0000;
                        endcase
                    end
                    default: imm = {$urandom, rnd};
                endcase
                add_req(4'($urandom_range(15)), 3'($urandom_range(7)),
                        3'($urandom_range(7)), imm);
            end

            while (pending_reqs.size() != 0 || expected_code.size() != 0) @(posedge i_clk);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/xobe_pkg.sv
rtl/xobe_encoder.sv
rtl/x86_64_op_byte_encoder.sv
tb/sv/x86_64_op_byte_encoder_tb.sv
